FILE: rtl/tal_pkg.sv
package tal_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 17;
    localparam int RUN_W     = 9;
    localparam int THR_W     = 15;
    localparam int LIMIT_W   = 8;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0]  GAIN_ONE      = 17'h10000;
    localparam logic [3:0]         EXTRA_RUN     = 4'd5;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd5;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 8'd10;
    localparam logic [GAIN_W-1:0]  STEP_RST      = 17'd4588;
    localparam logic [GAIN_W-1:0]  FLOOR_RST     = 17'd655;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 17'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TREND_THRESHOLD = 2'd0,
        REG_COUNT_LIMIT     = 2'd1,
        REG_GAIN_STEP       = 2'd2,
        REG_GAIN_FLOOR      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [THR_W-1:0]   trend_threshold;
        logic [LIMIT_W-1:0] count_limit;
        logic [GAIN_W-1:0]  gain_step;
        logic [GAIN_W-1:0]  gain_floor;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic [GAIN_W-1:0]          gain_now;
    } result_t;

endpackage

FILE: rtl/tal_stream_if.sv
interface tal_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tal_cfg_regs.sv
module tal_cfg_regs
    import tal_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_TREND_THRESHOLD: cfg_next.trend_threshold = cfg_wdata[THR_W-1:0];
                REG_COUNT_LIMIT:     cfg_next.count_limit     = cfg_wdata[LIMIT_W-1:0];
                REG_GAIN_STEP:       cfg_next.gain_step       = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_FLOOR:      cfg_next.gain_floor      = cfg_wdata[GAIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trend_threshold <= THRESHOLD_RST;
            cfg_reg.count_limit     <= LIMIT_RST;
            cfg_reg.gain_step       <= STEP_RST;
            cfg_reg.gain_floor      <= FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tal_core.sv
module tal_core
    import tal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  sample_t in_item,
    input  cfg_t    cfg,
    output result_t result
);

    logic signed [SAMPLE_W-1:0] fv_reg;
    logic signed [SAMPLE_W-1:0] fv_next;
    logic [GAIN_W-1:0]          gain_reg;
    logic [GAIN_W-1:0]          gain_next;
    logic [RUN_W-1:0]           run_reg;
    logic [RUN_W-1:0]           run_next;
    logic                       rising_reg;
    logic                       rising_next;

    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          mag;
    logic                       big_step;
    logic [RUN_W:0]             run_sum;
    logic [RUN_W-1:0]           run_inc;
    logic [GAIN_W:0]            gain_up;
    logic signed [GAIN_W+1:0]   gain_dn;
    logic signed [GAIN_W+1:0]   gain_fl;
    logic signed [GAIN_W+SAMPLE_W+1:0] prod;

    always_comb
    begin
        // a stored value of exactly zero is reloaded from the sample
        base = (fv_reg == '0) ? in_item.sample : fv_reg;
        diff = {in_item.sample[SAMPLE_W-1], in_item.sample} - {base[SAMPLE_W-1], base};

        if (diff[SAMPLE_W])
            rising_next = 1'b0;
        else if (diff != '0)
            rising_next = 1'b1;
        else
            rising_next = rising_reg;

        mag      = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
        big_step = mag > {2'b00, cfg.trend_threshold};
        run_sum  = {1'b0, run_reg} + (RUN_W+1)'(1)
                   + (big_step ? (RUN_W+1)'(EXTRA_RUN) : '0);
        run_inc  = run_sum[RUN_W-1:0];

        gain_up = {1'b0, gain_reg} + {1'b0, cfg.gain_step};
        gain_dn = $signed({2'b00, gain_reg}) - $signed({2'b00, cfg.gain_step});
        gain_fl = (gain_dn < $signed({2'b00, cfg.gain_floor}))
                  ? $signed({2'b00, cfg.gain_floor}) : gain_dn;

        if (rising_next == rising_reg)
        begin
            if (run_inc > {1'b0, cfg.count_limit})
            begin
                gain_next = (gain_up > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_up[GAIN_W-1:0];
                run_next  = '0;
            end
            else
            begin
                gain_next = gain_reg;
                run_next  = run_inc;
            end
        end
        else
        begin
            run_next  = '0;
            gain_next = (gain_fl > $signed({2'b00, GAIN_ONE}))
                        ? GAIN_ONE : gain_fl[GAIN_W-1:0];
        end

        // floor(gain * diff / 2^16); only the low 16 bits of the quotient matter
        prod    = (GAIN_W+SAMPLE_W+2)'($signed({1'b0, gain_next}))
                  * (GAIN_W+SAMPLE_W+2)'(diff);
        fv_next = base + prod[SAMPLE_W+15:16];

        result.filtered = fv_next;
        result.gain_now = gain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg     <= '0;
            gain_reg   <= GAIN_RST;
            run_reg    <= '0;
            rising_reg <= 1'b0;
        end
        else if (step)
        begin
            fv_reg     <= fv_next;
            gain_reg   <= gain_next;
            run_reg    <= run_next;
            rising_reg <= rising_next;
        end
    end

    a_gain_capped: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_ONE)
        else $error("gain above 1.0");

    a_turn_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        step && (rising_next != rising_reg) |=> run_reg == '0)
        else $error("run count not cleared on direction change");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(gain_reg) && $stable(fv_reg) && $stable(run_reg))
        else $error("filter state changed without a request");

endmodule

FILE: rtl/trend_adaptive_lowpass_filter.sv
// Channel   Dir  Payload                              Handshake
// samples   in   sample  (s16 Q8.8)                   valid/ready
// results   out  filtered (s16 Q8.8), gain_now (Q1.16) valid/ready
// cfg       in   cfg_addr 2b, cfg_wdata 17b           cfg_we, no back-pressure
//
// One request per cycle unless results stall; each sample is registered, then its result.
// The rate is set by the state feedback: gain update, one 18x17 multiply and the add
// are combinational between the input register and the result register.
// Reset (rst_n low, async) clears valid flags and filter state and loads register defaults.
// A stalled result holds the result register; the input register still takes one request.

module trend_adaptive_lowpass_filter
    import tal_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tal_stream_if.sink           samples,
    tal_stream_if.source         results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t    cfg;
    result_t core_result;

    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_item_reg;

    logic    advance;
    logic    fire;

    tal_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tal_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .in_item (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign advance       = !out_valid_reg || results.ready;
    assign fire          = in_valid_reg && advance;
    assign samples.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = samples.ready ? samples.valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            in_item_reg <= samples.data;
        if (fire)
            out_item_reg <= core_result;
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tal_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 67;
    localparam int MAX_PRINTS     = 50;

    typedef enum {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         known;
        result_t                    want;
        cfg_t                       cfg;
    } stim_row_t;

    typedef struct {
        bit      known;
        result_t val;
    } preset_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    tal_stream_if #(.payload_t(sample_t)) smp_if ();
    tal_stream_if #(.payload_t(result_t)) res_if ();

    trend_adaptive_lowpass_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // filter model state and register copy
    cfg_t                       cfg_now;
    logic signed [SAMPLE_W-1:0] level;
    logic [GAIN_W-1:0]          gain_q16;
    logic [RUN_W-1:0]           run_len;
    bit                         going_up;
    bit                         was_up;

    result_t expected_out[$];
    preset_t preset_q[$];
    stim_row_t stim_table[$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_sent;
    int n_directed;
    int n_checked;
    int n_cfg;
    int n_err;
    int n_full_gain;
    int n_zero_gain;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t filter_update(input logic signed [SAMPLE_W-1:0] smp);
        int      sv;
        int      diff;
        int      mag;
        int      run_n;
        longint  g;
        longint  p;
        result_t r;
        sv = smp;
        if (level == 0)
            level = smp;
        diff = sv - level;
        if (diff > 0)
            going_up = 1'b1;
        else if (diff < 0)
            going_up = 1'b0;
        if (going_up == was_up)
        begin
            mag = (diff < 0) ? -diff : diff;
            run_n = int'(run_len) + 1;
            if (mag > int'(cfg_now.trend_threshold))
                run_n += int'(EXTRA_RUN);
            run_n &= 'h1FF;
            if (run_n > int'(cfg_now.count_limit))
            begin
                g = longint'(gain_q16) + longint'(cfg_now.gain_step);
                if (g > longint'(GAIN_ONE))
                    g = longint'(GAIN_ONE);
                gain_q16 = GAIN_W'(g);
                run_n = 0;
            end
            run_len = RUN_W'(run_n);
        end
        else
        begin
            run_len = '0;
            g = longint'(gain_q16) - longint'(cfg_now.gain_step);
            if (g < longint'(cfg_now.gain_floor))
                g = longint'(cfg_now.gain_floor);
            if (g > longint'(GAIN_ONE))
                g = longint'(GAIN_ONE);
            gain_q16 = GAIN_W'(g);
        end
        // arithmetic shift gives the floor of the Q1.16 product
        p = longint'(gain_q16) * longint'(diff);
        level = SAMPLE_W'(longint'(level) + (p >>> 16));
        was_up = going_up;
        r.filtered = level;
        r.gain_now = gain_q16;
        return r;
    endfunction

    function automatic stim_row_t smp_row(input logic signed [SAMPLE_W-1:0] s);
        stim_row_t row;
        row.kind  = ROW_SAMPLE;
        row.smp   = s;
        row.known = 1'b0;
        row.want  = '0;
        row.cfg   = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic signed [SAMPLE_W-1:0] s,
                                            input logic signed [SAMPLE_W-1:0] filt,
                                            input logic [GAIN_W-1:0] g);
        stim_row_t row;
        row = smp_row(s);
        row.known         = 1'b1;
        row.want.filtered = filt;
        row.want.gain_now = g;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input int thr, input int lim,
                                          input int stp, input int flr);
        stim_row_t row;
        row.kind                = ROW_CONFIG;
        row.smp                 = '0;
        row.known               = 1'b0;
        row.want                = '0;
        row.cfg.trend_threshold = THR_W'(thr);
        row.cfg.count_limit     = LIMIT_W'(lim);
        row.cfg.gain_step       = GAIN_W'(stp);
        row.cfg.gain_floor      = GAIN_W'(flr);
        return row;
    endfunction

    // zero, the top of the range, or something near the low end or anywhere
    function automatic int pick_value(input int hi, input int near);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return hi;
            2:       return int'($urandom_range(0, near));
            default: return int'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit known,
                               input result_t want);
        preset_t h;
        h.known = known;
        h.val   = want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        preset_q.push_back(h);
        smp_if.valid       <= 1'b1;
        smp_if.data.sample <= s;
        do
            @(posedge clk);
        while (!smp_if.ready);
        n_sent++;
    endtask

    task automatic apply_cfg(input cfg_t c);
        smp_if.valid <= 1'b0;
        // let the monitor log the last accepted request before checking the queue
        @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        cfg_now = c;
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TREND_THRESHOLD;
        cfg_wdata <= CFG_W'(c.trend_threshold);
        @(posedge clk);
        cfg_addr  <= REG_COUNT_LIMIT;
        cfg_wdata <= CFG_W'(c.count_limit);
        @(posedge clk);
        cfg_addr  <= REG_GAIN_STEP;
        cfg_wdata <= CFG_W'(c.gain_step);
        @(posedge clk);
        cfg_addr  <= REG_GAIN_FLOOR;
        cfg_wdata <= CFG_W'(c.gain_floor);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    // receiver back-pressure
    always @(posedge clk)
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : monitor
        result_t pred;
        result_t exp_r;
        preset_t h;
        if (rst_n)
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                pred = filter_update(smp_if.data.sample);
                h = preset_q.pop_front();
                expected_out.push_back(h.known ? h.val : pred);
            end
            if (res_if.valid && res_if.ready)
            begin
                if (res_if.data.gain_now == GAIN_ONE)
                    n_full_gain++;
                if (res_if.data.gain_now == 0)
                    n_zero_gain++;
                if (expected_out.size() == 0)
                begin
                    if (n_err < MAX_PRINTS)
                        $display("%0t: result with nothing expected: filtered %0d gain %0d",
                                 $time, res_if.data.filtered, res_if.data.gain_now);
                    n_err++;
                end
                else
                begin
                    exp_r = expected_out.pop_front();
                    n_checked++;
                    if (res_if.data.filtered !== exp_r.filtered)
                    begin
                        if (n_err < MAX_PRINTS)
                            $display("%0t: filtered mismatch: expected %0d actual %0d",
                                     $time, exp_r.filtered, res_if.data.filtered);
                        n_err++;
                    end
                    if (res_if.data.gain_now !== exp_r.gain_now)
                    begin
                        if (n_err < MAX_PRINTS)
                            $display("%0t: gain_now mismatch: expected %0d actual %0d",
                                     $time, exp_r.gain_now, res_if.data.gain_now);
                        n_err++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        cfg_t      c;
        result_t   none;
        int        cur;
        int        dir;
        int        delta;
        int        max_step;
        int        r;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_TREND_THRESHOLD;
        cfg_wdata    = '0;
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        none         = '0;
        idle_cycles  = 0;
        n_sent = 0; n_directed = 0; n_checked = 0; n_cfg = 0; n_err = 0;
        n_full_gain = 0; n_zero_gain = 0;

        cfg_now.trend_threshold = THRESHOLD_RST;
        cfg_now.count_limit     = LIMIT_RST;
        cfg_now.gain_step       = STEP_RST;
        cfg_now.gain_floor      = FLOOR_RST;
        level    = '0;
        gain_q16 = GAIN_RST;
        run_len  = '0;
        going_up = 1'b0;
        was_up   = 1'b0;

        send_idle_pct = 37;
        recv_idle_pct = 70;

        // reset defaults: first sample loads the empty filter, then extremes,
        // a held level, a rising run of large steps, then alternating swings
        stim_table.push_back(known_row(16'sh7FFF, 16'sh7FFF, GAIN_RST));
        stim_table.push_back(smp_row(16'sh8000));
        stim_table.push_back(smp_row(16'sh0000));
        stim_table.push_back(smp_row(16'sh0100));
        stim_table.push_back(smp_row(16'sh0100));
        repeat (5)
            stim_table.push_back(smp_row(16'sh7000));
        stim_table.push_back(smp_row(-16'sh1000));
        stim_table.push_back(smp_row(16'sh1000));
        stim_table.push_back(smp_row(-16'sh1000));
        stim_table.push_back(smp_row(16'sh1000));
        // full gain either way: output tracks the sample, zero level reloads
        stim_table.push_back(cfg_row(0, 0, int'(GAIN_ONE), int'(GAIN_ONE)));
        stim_table.push_back(known_row(16'sh0000, 16'sh0000, GAIN_ONE));
        stim_table.push_back(known_row(16'sh0000, 16'sh0000, GAIN_ONE));
        stim_table.push_back(known_row(16'sh1234, 16'sh1234, GAIN_ONE));
        stim_table.push_back(known_row(16'sh8000, 16'sh8000, GAIN_ONE));
        stim_table.push_back(known_row(16'sh7FFF, 16'sh7FFF, GAIN_ONE));
        stim_table.push_back(known_row(-16'sh0001, -16'sh0001, GAIN_ONE));
        // widest threshold and limit, zero floor: swings drive gain to zero
        stim_table.push_back(cfg_row((1 << THR_W) - 1, (1 << LIMIT_W) - 1,
                                     int'(GAIN_ONE), 0));
        stim_table.push_back(smp_row(16'sh0100));
        stim_table.push_back(smp_row(16'sh0200));
        stim_table.push_back(smp_row(16'sh0100));
        stim_table.push_back(smp_row(16'sh0200));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_CONFIG)
                apply_cfg(row.cfg);
            else
            begin
                send_sample(row.smp, row.known, row.want);
                n_directed++;
            end
        end

        cur = 0;
        dir = 1;
        for (int mode = 0; mode < 3; mode++)
        begin
            for (int sub = 0; sub < 2; sub++)
            begin
                c.trend_threshold = THR_W'(pick_value((1 << THR_W) - 1, 64));
                c.count_limit     = LIMIT_W'(pick_value((1 << LIMIT_W) - 1, 20));
                c.gain_step       = GAIN_W'(pick_value(int'(GAIN_ONE), 8192));
                c.gain_floor      = GAIN_W'(pick_value(int'(GAIN_ONE), 2000));
                apply_cfg(c);
                case (mode)
                    0:
                    begin
                        send_idle_pct = 37;
                        recv_idle_pct = 70;
                    end
                    1:
                    begin
                        send_idle_pct = 70;
                        recv_idle_pct = 37;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                case ($urandom_range(0, 2))
                    0:       max_step = 3;
                    1:       max_step = 40;
                    default: max_step = 1500;
                endcase
                // mostly trending runs with occasional reversals, some raw noise
                repeat (RANDOM_ITEMS)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        cur = int'($signed(16'($urandom)));
                    else
                    begin
                        if (r < 25)
                            dir = -dir;
                        delta = int'($urandom_range(0, max_step));
                        cur += dir * delta;
                        if (cur > 32767)
                        begin
                            cur = 32767;
                            dir = -1;
                        end
                        if (cur < -32768)
                        begin
                            cur = -32768;
                            dir = 1;
                        end
                    end
                    send_sample(SAMPLE_W'(cur), 1'b0, none);
                end
            end
        end

        smp_if.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_out.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_out.size());
            n_err++;
        end

        $display("Sent %0d samples (%0d from the table) under %0d register settings,",
                 n_sent, n_directed, n_cfg);
        $display("%0d results checked; gain at full scale in %0d, at zero in %0d; %0d errors.",
                 n_checked, n_full_gain, n_zero_gain, n_err);
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
